>>> hw/rtl/qpsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qpsl_pkg;

  localparam int CHANNELS = 4;
  localparam int TIMER_W  = 32;
  localparam int SKEW_W   = 12;
  localparam int LEVEL_W  = 10;
  localparam int TICKS_W  = 8;
  localparam int STEP_W   = 29;
  localparam int CFG_IDX_W = 2;

  localparam logic [SKEW_W-1:0]  SKEW_CURVE  = 12'd130;
  localparam logic [SKEW_W-1:0]  SKEW_CUBIC  = 12'd90;
  localparam logic [SKEW_W-1:0]  SKEW_QUAD   = 12'd55;
  localparam logic [SKEW_W-1:0]  SKEW_TRIG   = 12'd30;
  localparam logic [SKEW_W-1:0]  SKEW_MID_LO = 12'd1975;
  localparam logic [SKEW_W-1:0]  SKEW_MID_HI = 12'd2125;
  localparam logic [SKEW_W-1:0]  SKEW_HIGH   = 12'd4000;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 10'd1023;
  localparam logic [TIMER_W-1:0] OFFSET_MARGIN = 32'd20;
  localparam logic [TIMER_W-1:0] PING_JITTER   = 32'd10;
  localparam logic [TIMER_W-1:0] PERIOD_RESET  = 32'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIFT = 2'd0,
    REG_HOLD  = 2'd1,
    REG_TRACK = 2'd2,
    REG_TRIG  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2,
    PH_SPARE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RUN_STOP  = 2'd0,
    RUN_ARMED = 2'd1,
    RUN_GO    = 2'd2,
    RUN_SPARE = 2'd3
  } run_t;

  typedef struct packed {
    logic [11:0] drift_threshold;
    logic [15:0] hold_clear_ticks;
    logic [11:0] skew_track_ticks;
    logic [7:0]  trig_width;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic               ack;
    logic [TICKS_W-1:0] ticks;
    logic               tap;
    logic               ping;
    logic               jack;
    logic [SKEW_W-1:0]  skew;
  } lane_ctl_t;

  typedef struct packed {
    logic               done;
    logic               led;
    logic [LEVEL_W-1:0] level;
  } lane_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/qpsl_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface qpsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_ticks;
  logic [3:0] tap_levels;
  logic [3:0] ping_levels;
  logic [3:0] reset_levels;
  logic [11:0] skew_ch0;
  logic [11:0] skew_ch1;
  logic [11:0] skew_ch2;
  logic [11:0] skew_ch3;
  modport source (output valid, elapsed_ticks, tap_levels, ping_levels, reset_levels,
                  skew_ch0, skew_ch1, skew_ch2, skew_ch3, input ready);
  modport sink (input valid, elapsed_ticks, tap_levels, ping_levels, reset_levels,
                skew_ch0, skew_ch1, skew_ch2, skew_ch3, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/qpsl_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface qpsl_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] level_ch0;
  logic [9:0] level_ch1;
  logic [9:0] level_ch2;
  logic [9:0] level_ch3;
  logic [3:0] led_bits;
  modport source (output valid, level_ch0, level_ch1, level_ch2, level_ch3, led_bits,
                  input ready);
  modport sink (input valid, level_ch0, level_ch1, level_ch2, level_ch3, led_bits,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/qpsl_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface qpsl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/quad_ping_skew_lfo.sv
`timescale 1ns / 1ps
`default_nettype none
// Four-channel tempo-locked skewed LFO. Each accepted item carries the elapsed timer ticks,
// the tap, ping and reset jack levels and four skew readings; each item yields exactly one
// result with the four 10-bit levels and the tap LED bits. The four channels run in four
// lanes side by side and the result stage merges their levels and LED bits. One item at a
// time is in flight. When a skew or period change forces a recompute, the lane's
// bit-serial divider forms the 2^28 reciprocal steps of the rise and fall lengths, one
// after the other. A curved shape adds squaring steps, and the slowest lane sets the pace.
// With elapsed_ticks of zero the levels hold their previous value. Configuration writes
// are taken at any time but must only be issued while the block is idle.
module quad_ping_skew_lfo (
  input logic       clk,
  input logic       rst,
  qpsl_in_if.sink   sample,
  qpsl_out_if.source result,
  qpsl_cfg_if.sink  cfg
);
  qpsl_pkg::cfg_t       cfg_regs;
  qpsl_pkg::lane_ctl_t  ctl    [qpsl_pkg::CHANNELS];
  qpsl_pkg::lane_stat_t stat   [qpsl_pkg::CHANNELS];
  logic [11:0]          skews  [qpsl_pkg::CHANNELS];
  logic [qpsl_pkg::CHANNELS-1:0] lane_done;

  logic busy;       // an item is inside the lanes
  logic accept;     // input transfer
  logic load;       // lanes finished and the output slot is free

  assign cfg.ready = 1'b1;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.drift_threshold  <= 12'd50;
      cfg_regs.hold_clear_ticks <= 16'd15000;
      cfg_regs.skew_track_ticks <= 12'd4000;
      cfg_regs.trig_width       <= 8'd50;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        qpsl_pkg::REG_DRIFT: cfg_regs.drift_threshold  <= cfg.data[11:0];
        qpsl_pkg::REG_HOLD:  cfg_regs.hold_clear_ticks <= cfg.data;
        qpsl_pkg::REG_TRACK: cfg_regs.skew_track_ticks <= cfg.data[11:0];
        qpsl_pkg::REG_TRIG:  cfg_regs.trig_width       <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  assign sample.ready = !busy;
  assign accept       = sample.valid && !busy;
  assign load         = busy && (&lane_done) && (!result.valid || result.ready);

  assign skews[0] = sample.skew_ch0;
  assign skews[1] = sample.skew_ch1;
  assign skews[2] = sample.skew_ch2;
  assign skews[3] = sample.skew_ch3;

  // one lane per channel, all start on the same transfer
  for (genvar i = 0; i < qpsl_pkg::CHANNELS; i++) begin : g_lane
    assign ctl[i].start = accept;
    assign ctl[i].ack   = load;
    assign ctl[i].ticks = sample.elapsed_ticks;
    assign ctl[i].tap   = sample.tap_levels[i];
    assign ctl[i].ping  = sample.ping_levels[i];
    assign ctl[i].jack  = sample.reset_levels[i];
    assign ctl[i].skew  = skews[i];
    assign lane_done[i] = stat[i].done;

    qpsl_lane u_lane (
      .clk(clk), .rst(rst), .ctl(ctl[i]), .cfg(cfg_regs), .stat(stat[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (accept) busy <= 1'b1;
      else if (load) busy <= 1'b0;
      if (load) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  // merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (load) begin
      result.level_ch0 <= stat[0].level;
      result.level_ch1 <= stat[1].level;
      result.level_ch2 <= stat[2].level;
      result.level_ch3 <= stat[3].level;
      result.led_bits  <= {stat[3].led, stat[2].led, stat[1].led, stat[0].led};
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("item transfer did not mark the lanes busy");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> result.valid) else $error("finished lanes did not fill the output slot");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({accept, load})) else $error("transfer in and merge in the same cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (|lane_done) |-> busy) else $error("a lane finished with no item in flight");
endmodule
`default_nettype wire

>>> hw/rtl/qpsl_div.sv
`timescale 1ns / 1ps
`default_nettype none
// 2^28 / divisor, one quotient bit per cycle, zero divides as one
module qpsl_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [qpsl_pkg::STEP_W-1:0] quotient
);
  localparam int CNT_W = $clog2(qpsl_pkg::STEP_W + 1);

  logic [31:0]      den;
  logic [31:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      rem_sh;
  logic             ge;

  assign rem_sh = {rem, (cnt == CNT_W'(qpsl_pkg::STEP_W))};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den      <= (divisor == 32'd0) ? 32'd1 : divisor;
        rem      <= '0;
        quotient <= '0;
        cnt      <= CNT_W'(qpsl_pkg::STEP_W);
      end else if (cnt != '0) begin
        rem      <= ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
        quotient <= {quotient[qpsl_pkg::STEP_W-2:0], ge};
        cnt      <= cnt - 1'b1;
        done     <= (cnt == CNT_W'(1));
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/qpsl_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module qpsl_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  qpsl_pkg::lane_ctl_t  ctl,
  input  qpsl_pkg::cfg_t       cfg,
  output qpsl_pkg::lane_stat_t stat
);
  typedef enum logic [3:0] {
    S_IDLE, S_PASS, S_MUL, S_LEN, S_DIVR, S_DIVF,
    S_ENV0, S_ENVM, S_ENV1, S_SHAPE, S_SQ, S_DONE
  } state_t;

  state_t state;

  logic [31:0] ping_timer, reset_timer, tap_timer, flash_timer, period_ticks, reset_offset;
  qpsl_pkg::run_t   run_mode;
  qpsl_pkg::phase_t phase;
  logic tap_prev, ping_prev, reset_prev, led_on, rearm, restart_pending;
  logic [11:0] skew_value, skew_hold_count;
  logic [31:0] fall_len, accumulator, since_restart;
  logic [qpsl_pkg::STEP_W-1:0] rise_step, fall_step;
  logic [7:0]  shape_select;
  logic [9:0]  level_hold, lvl;
  logic [1:0]  sq_idx;

  // latched item
  logic [7:0]  ticks;
  logic        tap, ping, jack;
  logic [11:0] skew_in;

  logic [43:0] rise_prod;
  logic [36:0] env_prod;
  logic        need_rc;

  // pass results
  logic [31:0] p_ping, p_rt, p_tap, p_flash, p_period, p_off, p_d;
  qpsl_pkg::run_t p_run;
  logic p_tprev, p_pprev, p_rprev, p_led, p_rearm, p_restart, p_chg, p_rc;
  logic [11:0] p_skew, p_hold, p_sd;

  // recompute / envelope helpers
  logic [31:0] rl;
  logic [13:0] low_lim;
  logic        div_start, div_done;
  logic [31:0] div_den;
  logic [qpsl_pkg::STEP_W-1:0] div_q;
  logic [37:0] amt;
  logic [31:0] acc_dn;
  logic [13:0] lvl_dn;
  logic [19:0] sq;
  logic [7:0]  shape_pick;

  always_comb begin
    p_ping = ping_timer; p_rt = reset_timer; p_tap = tap_timer; p_flash = flash_timer;
    p_period = period_ticks; p_off = reset_offset; p_run = run_mode;
    p_tprev = tap_prev; p_pprev = ping_prev; p_rprev = reset_prev; p_led = led_on;
    p_rearm = rearm; p_restart = restart_pending; p_chg = 1'b0; p_rc = 1'b0;
    p_skew = skew_value; p_hold = skew_hold_count; p_d = '0; p_sd = '0;

    if (tap) begin
      if (!p_tprev) begin
        if (p_run == qpsl_pkg::RUN_ARMED) p_run = qpsl_pkg::RUN_GO;
        else if (p_run == qpsl_pkg::RUN_STOP) p_run = qpsl_pkg::RUN_ARMED;
        p_led = 1'b1; p_tprev = 1'b1; p_period = p_tap; p_tap = '0;
        p_flash = '0; p_rt = '0; p_rearm = 1'b1; p_chg = 1'b1;
      end
      if (p_tap > {16'd0, cfg.hold_clear_ticks}) begin
        if (p_run != qpsl_pkg::RUN_STOP) p_led = 1'b0;
        p_run = qpsl_pkg::RUN_STOP;
      end
    end else if (p_tprev) begin
      p_tprev = 1'b0; p_led = 1'b0;
    end

    if (ping) begin
      if (!p_pprev) begin
        p_run = qpsl_pkg::RUN_GO; p_led = 1'b1; p_pprev = 1'b1;
        p_d = (p_ping > p_period) ? p_ping - p_period : p_period - p_ping;
        if (p_d > qpsl_pkg::PING_JITTER) begin
          p_period = p_ping; p_chg = 1'b1;
        end
        p_ping = '0; p_flash = '0; p_rt = '0; p_rearm = 1'b1;
      end
    end else if (p_pprev) begin
      p_pprev = 1'b0; p_led = 1'b0;
    end

    if (p_run == qpsl_pkg::RUN_GO) begin
      if (p_led && p_flash >= (p_period >> 1)) p_led = 1'b0;
      if (p_flash >= p_period) begin
        p_flash = p_flash - p_period; p_rt = p_flash; p_led = 1'b1; p_rearm = 1'b1;
      end
    end

    if (p_chg) begin
      p_rt = '0;
      if ({1'b0, p_off} + {1'b0, qpsl_pkg::OFFSET_MARGIN} >= {1'b0, p_period}) p_off = '0;
      p_rearm = 1'b1; p_rc = 1'b1;
    end

    if (jack) begin
      if (!p_rprev) begin
        p_off = p_rt;
        if ({1'b0, p_off} + {1'b0, qpsl_pkg::OFFSET_MARGIN} >= {1'b0, p_period}) p_off = '0;
        p_restart = 1'b1; p_rprev = 1'b1; p_rearm = 1'b0;
      end else if (phase != qpsl_pkg::PH_WAIT) begin
        p_rearm = 1'b0;
      end
    end else begin
      p_rprev = 1'b0;
    end

    if (p_rearm && p_rt > p_off) begin
      if (p_hold == '0 || phase == qpsl_pkg::PH_WAIT) p_restart = 1'b1;
      p_rearm = 1'b0;
    end

    p_sd = (p_skew > skew_in) ? p_skew - skew_in : skew_in - p_skew;
    if (p_sd > cfg.drift_threshold) begin
      p_hold = cfg.skew_track_ticks; p_skew = skew_in; p_rc = 1'b1;
    end else if (p_hold != '0) begin
      p_hold = p_hold - 1'b1;
    end
  end

  // rise length from the skew reading
  assign low_lim = 14'(qpsl_pkg::SKEW_CURVE) + {1'b0, cfg.drift_threshold, 1'b0};
  always_comb begin
    if ({2'b00, skew_value} <= low_lim) rl = 32'd1;
    else if (skew_value > qpsl_pkg::SKEW_HIGH) rl = period_ticks - 32'd1;
    else if (skew_value > qpsl_pkg::SKEW_MID_LO && skew_value < qpsl_pkg::SKEW_MID_HI)
      rl = period_ticks >> 1;
    else rl = rise_prod[43:12];
  end

  assign div_start = (state == S_LEN) || (state == S_DIVR && div_done);
  assign div_den   = (state == S_LEN) ? rl : fall_len;

  qpsl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(div_den),
    .done(div_done), .quotient(div_q)
  );

  assign amt    = {6'd0, accumulator} + {1'b0, env_prod};
  assign acc_dn = ({5'd0, accumulator} > env_prod) ? 32'({5'd0, accumulator} - env_prod) : '0;
  assign lvl_dn = acc_dn[31:18];
  assign sq     = lvl * lvl;
  assign shape_pick = (skew_value <= qpsl_pkg::SKEW_CURVE) ?
                      ((skew_value <= qpsl_pkg::SKEW_TRIG) ? 8'd1 : skew_value[7:0]) : 8'd0;

  assign stat.done  = (state == S_DONE);
  assign stat.led   = led_on;
  assign stat.level = level_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ping_timer <= '0; reset_timer <= '0; tap_timer <= '0; flash_timer <= '0;
      period_ticks <= qpsl_pkg::PERIOD_RESET; reset_offset <= '0;
      run_mode <= qpsl_pkg::RUN_STOP; phase <= qpsl_pkg::PH_WAIT;
      tap_prev <= 1'b0; ping_prev <= 1'b0; reset_prev <= 1'b0; led_on <= 1'b0;
      rearm <= 1'b0; restart_pending <= 1'b0;
      skew_value <= '0; skew_hold_count <= '0;
      fall_len <= '0; rise_step <= '0; fall_step <= '0;
      accumulator <= '0; shape_select <= '0; since_restart <= '0; level_hold <= '0;
      need_rc <= 1'b0; sq_idx <= '0; lvl <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            ticks <= ctl.ticks; tap <= ctl.tap; ping <= ctl.ping; jack <= ctl.jack;
            skew_in <= ctl.skew;
            ping_timer  <= ping_timer  + {24'd0, ctl.ticks};
            reset_timer <= reset_timer + {24'd0, ctl.ticks};
            tap_timer   <= tap_timer   + {24'd0, ctl.ticks};
            flash_timer <= flash_timer + {24'd0, ctl.ticks};
            state <= S_PASS;
          end
        end
        S_PASS: begin
          ping_timer <= p_ping; reset_timer <= p_rt; tap_timer <= p_tap;
          flash_timer <= p_flash; period_ticks <= p_period; reset_offset <= p_off;
          run_mode <= p_run; tap_prev <= p_tprev; ping_prev <= p_pprev;
          reset_prev <= p_rprev; led_on <= p_led; rearm <= p_rearm;
          restart_pending <= p_restart; skew_value <= p_skew; skew_hold_count <= p_hold;
          need_rc <= p_rc;
          state <= S_MUL;
        end
        S_MUL: begin
          rise_prod <= skew_value * period_ticks;
          if (need_rc) state <= S_LEN;
          else state <= (ticks != '0) ? S_ENV0 : S_DONE;
        end
        S_LEN: begin
          fall_len <= period_ticks - rl;
          state <= S_DIVR;
        end
        S_DIVR: begin
          if (div_done) begin
            rise_step <= div_q;
            state <= S_DIVF;
          end
        end
        S_DIVF: begin
          if (div_done) begin
            fall_step <= div_q;
            state <= (ticks != '0) ? S_ENV0 : S_DONE;
          end
        end
        S_ENV0: begin
          if (restart_pending) begin
            restart_pending <= 1'b0;
            phase <= qpsl_pkg::PH_RISE;
            shape_select <= shape_pick;
            accumulator <= '0;
            since_restart <= 32'd1;
          end else begin
            since_restart <= since_restart + 32'd1;
          end
          state <= S_ENVM;
        end
        S_ENVM: begin
          env_prod <= ((phase == qpsl_pkg::PH_RISE) ? rise_step : fall_step) * ticks;
          state <= S_ENV1;
        end
        S_ENV1: begin
          case (phase)
            qpsl_pkg::PH_RISE: begin
              if (amt[37:18] >= 20'(qpsl_pkg::LEVEL_TOP)) begin
                accumulator <= {4'd0, qpsl_pkg::LEVEL_TOP, 18'd0};
                lvl <= qpsl_pkg::LEVEL_TOP;
                phase <= qpsl_pkg::PH_FALL;
              end else begin
                accumulator <= amt[31:0];
                lvl <= amt[27:18];
              end
            end
            qpsl_pkg::PH_FALL: begin
              accumulator <= acc_dn;
              lvl <= lvl_dn[9:0];
              if (lvl_dn == '0 || lvl_dn > 14'(qpsl_pkg::LEVEL_TOP)) begin
                accumulator <= '0;
                lvl <= '0;
                phase <= qpsl_pkg::PH_WAIT;
                if ((jack || skew_hold_count != '0) && (reset_timer >> 1) < period_ticks) begin
                  phase <= qpsl_pkg::PH_RISE;
                  shape_select <= shape_pick;
                  since_restart <= '0;
                end
              end
            end
            default: begin
              phase <= qpsl_pkg::PH_WAIT;
              accumulator <= '0;
              lvl <= '0;
            end
          endcase
          sq_idx <= '0;
          state <= S_SHAPE;
        end
        S_SHAPE: begin
          if (shape_select == 8'd1) begin
            level_hold <= (since_restart < {24'd0, cfg.trig_width}) ? qpsl_pkg::LEVEL_TOP
                                                                     : 10'd1;
            state <= S_DONE;
          end else if (shape_select == 8'd0) begin
            level_hold <= lvl;
            state <= S_DONE;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          // first squaring always, then cubic and quad ranges add one each
          if (sq_idx == 2'd0 ||
              (sq_idx == 2'd1 && {4'd0, shape_select} <= qpsl_pkg::SKEW_CUBIC) ||
              (sq_idx == 2'd2 && {4'd0, shape_select} <= qpsl_pkg::SKEW_QUAD))
            lvl <= sq[19:10];
          sq_idx <= sq_idx + 2'd1;
          if (sq_idx == 2'd3) begin
            level_hold <= lvl;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (ctl.ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sim/quad_ping_skew_lfo_tb.sv
`timescale 1ns / 1ps
module quad_ping_skew_lfo_tb;

  // one result transfer: four levels and the tap leds
  typedef struct {
    bit [9:0] lvl [4];
    bit [3:0] leds;
  } lfo_out_t;

  // shadow of the four lfo channels plus the queue of levels still owed by the block
  class lfo_tracker;
    bit [31:0] ping_t [4], jack_t [4], tap_t [4], flash_t [4], period [4];
    qpsl_pkg::run_t mode [4];
    bit        tap_q [4], ping_q [4], jack_q [4], led [4], per_chg [4], rearm [4], restart [4];
    bit [31:0] offset [4], rise_len [4], fall_len [4], rise_stp [4], fall_stp [4], acc [4];
    bit [31:0] since [4];
    bit [11:0] skew [4], hold_cnt [4];
    qpsl_pkg::phase_t ph [4];
    bit [7:0]  shape [4];
    bit [9:0]  lvl_q [4];
    bit [31:0] drift, hold_clr, track, trig_w;
    lfo_out_t  levels_due [$];
    int        errors;

    function new();
      for (int c = 0; c < 4; c++) begin
        ping_t[c] = 0; jack_t[c] = 0; tap_t[c] = 0; flash_t[c] = 0;
        period[c] = qpsl_pkg::PERIOD_RESET; mode[c] = qpsl_pkg::RUN_STOP;
        tap_q[c] = 0; ping_q[c] = 0; jack_q[c] = 0; led[c] = 0; per_chg[c] = 0;
        rearm[c] = 0; restart[c] = 0; offset[c] = 0; rise_len[c] = 0; fall_len[c] = 0;
        rise_stp[c] = 0; fall_stp[c] = 0; acc[c] = 0; since[c] = 0; skew[c] = 0;
        hold_cnt[c] = 0; ph[c] = qpsl_pkg::PH_WAIT; shape[c] = 0; lvl_q[c] = 0;
      end
      drift = 50; hold_clr = 15000; track = 4000; trig_w = 50; errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(qpsl_pkg::reg_idx_t idx, bit [15:0] val);
      case (idx)
        qpsl_pkg::REG_DRIFT: drift = 32'(val[11:0]);
        qpsl_pkg::REG_HOLD:  hold_clr = 32'(val);
        qpsl_pkg::REG_TRACK: track = 32'(val[11:0]);
        qpsl_pkg::REG_TRIG:  trig_w = 32'(val[7:0]);
        default: ;
      endcase
    endfunction

    function bit [31:0] rise_of(bit [31:0] sk, bit [31:0] per);
      bit [63:0] prod;
      prod = 64'(sk) * 64'(per);
      if (sk <= 32'(qpsl_pkg::SKEW_CURVE) + 2 * drift) return 1;
      if (sk > 32'(qpsl_pkg::SKEW_HIGH)) return per - 1;
      if (sk > 32'(qpsl_pkg::SKEW_MID_LO) && sk < 32'(qpsl_pkg::SKEW_MID_HI)) return per >> 1;
      return prod[43:12];
    endfunction

    // rise/fall split and the 2^28 reciprocal steps, zero length divides as one
    function void split_period(int c);
      rise_len[c] = rise_of(32'(skew[c]), period[c]);
      fall_len[c] = period[c] - rise_len[c];
      rise_stp[c] = 32'h1000_0000 / (rise_len[c] != 0 ? rise_len[c] : 32'd1);
      fall_stp[c] = 32'h1000_0000 / (fall_len[c] != 0 ? fall_len[c] : 32'd1);
    endfunction

    function void clip_offset(int c);
      if (33'(offset[c]) + 33'd20 >= 33'(period[c])) offset[c] = 0;
    endfunction

    function void pick_shape(int c);
      if (skew[c] <= qpsl_pkg::SKEW_CURVE)
        shape[c] = (skew[c] <= qpsl_pkg::SKEW_TRIG) ? 8'd1 : skew[c][7:0];
      else shape[c] = 0;
    endfunction

    function void channel_pass(int c, bit tap, bit ping, bit jack, bit [11:0] sk);
      bit [31:0] d, now;
      bit [11:0] sd;
      if (tap) begin
        if (!tap_q[c]) begin
          if (mode[c] == qpsl_pkg::RUN_ARMED) mode[c] = qpsl_pkg::RUN_GO;
          else if (mode[c] == qpsl_pkg::RUN_STOP) mode[c] = qpsl_pkg::RUN_ARMED;
          led[c] = 1; tap_q[c] = 1; period[c] = tap_t[c];
          tap_t[c] = 0; flash_t[c] = 0; jack_t[c] = 0; rearm[c] = 1; per_chg[c] = 1;
        end
        if (tap_t[c] > hold_clr) begin
          if (mode[c] != qpsl_pkg::RUN_STOP) led[c] = 0;
          mode[c] = qpsl_pkg::RUN_STOP;
        end
      end else if (tap_q[c]) begin
        tap_q[c] = 0; led[c] = 0;
      end

      if (ping) begin
        if (!ping_q[c]) begin
          mode[c] = qpsl_pkg::RUN_GO; led[c] = 1; ping_q[c] = 1;
          d = (ping_t[c] > period[c]) ? ping_t[c] - period[c] : period[c] - ping_t[c];
          if (d > qpsl_pkg::PING_JITTER) begin
            period[c] = ping_t[c]; per_chg[c] = 1;
          end
          ping_t[c] = 0; flash_t[c] = 0; jack_t[c] = 0; rearm[c] = 1;
        end
      end else if (ping_q[c]) begin
        ping_q[c] = 0; led[c] = 0;
      end

      if (mode[c] == qpsl_pkg::RUN_GO) begin
        now = flash_t[c];
        if (led[c] && now >= (period[c] >> 1)) led[c] = 0;
        if (now >= period[c]) begin
          flash_t[c] = now - period[c]; jack_t[c] = flash_t[c]; led[c] = 1; rearm[c] = 1;
        end
      end

      if (per_chg[c]) begin
        per_chg[c] = 0; jack_t[c] = 0; clip_offset(c); rearm[c] = 1; split_period(c);
      end

      if (jack) begin
        if (!jack_q[c]) begin
          offset[c] = jack_t[c]; clip_offset(c);
          restart[c] = 1; jack_q[c] = 1; rearm[c] = 0;
        end else if (ph[c] != qpsl_pkg::PH_WAIT) begin
          rearm[c] = 0;
        end
      end else begin
        jack_q[c] = 0;
      end

      if (rearm[c] && jack_t[c] > offset[c]) begin
        if (hold_cnt[c] == 0 || ph[c] == qpsl_pkg::PH_WAIT) restart[c] = 1;
        rearm[c] = 0;
      end

      sd = (skew[c] > sk) ? skew[c] - sk : sk - skew[c];
      if (32'(sd) > drift) begin
        hold_cnt[c] = track[11:0]; skew[c] = sk; split_period(c);
      end else if (hold_cnt[c] > 0) begin
        hold_cnt[c]--;
      end
    endfunction

    function bit [31:0] sq10(bit [31:0] x);
      return (x * x) >> 10;
    endfunction

    function void envelope(int c, bit [7:0] tk, bit jack);
      bit [31:0] level;
      bit [63:0] amt;
      level = 0;
      if (restart[c]) begin
        restart[c] = 0; ph[c] = qpsl_pkg::PH_RISE; pick_shape(c); acc[c] = 0; since[c] = 0;
      end
      since[c]++;
      if (ph[c] == qpsl_pkg::PH_RISE) begin
        amt = 64'(acc[c]) + 64'(rise_stp[c]) * 64'(tk);
        // overshoot, carry out of 32 bits included, pins the level at the top
        if ((amt >> 18) >= 64'(qpsl_pkg::LEVEL_TOP)) begin
          acc[c] = 32'(qpsl_pkg::LEVEL_TOP) << 18; level = 32'(qpsl_pkg::LEVEL_TOP);
          ph[c] = qpsl_pkg::PH_FALL;
        end else begin
          acc[c] = amt[31:0]; level = acc[c] >> 18;
        end
      end else if (ph[c] == qpsl_pkg::PH_FALL) begin
        amt = 64'(fall_stp[c]) * 64'(tk);
        acc[c] = (64'(acc[c]) > amt) ? acc[c] - amt[31:0] : 32'd0;
        level = acc[c] >> 18;
        if (level < 1 || level > 32'(qpsl_pkg::LEVEL_TOP)) begin
          acc[c] = 0; level = 0; ph[c] = qpsl_pkg::PH_WAIT;
          if ((jack || hold_cnt[c] > 0) && (jack_t[c] >> 1) < period[c]) begin
            ph[c] = qpsl_pkg::PH_RISE; pick_shape(c); since[c] = 0;
          end
        end
      end else begin
        // spare phase code behaves as wait
        ph[c] = qpsl_pkg::PH_WAIT; acc[c] = 0;
      end
      if (shape[c] == 1) begin
        level = (since[c] < trig_w) ? 32'(qpsl_pkg::LEVEL_TOP) : 32'd1;
      end else if (shape[c] != 0) begin
        level = sq10(level);
        if (shape[c] <= qpsl_pkg::SKEW_CUBIC) level = sq10(level);
        if (shape[c] <= qpsl_pkg::SKEW_QUAD) level = sq10(level);
      end
      lvl_q[c] = level[9:0];
    endfunction

    // accepted sample transfer: advance the shadow and queue the owed result
    function void take_sample(bit [7:0] tk, bit [3:0] taps, bit [3:0] pings,
                              bit [3:0] jacks, bit [11:0] sk [4]);
      lfo_out_t e;
      for (int c = 0; c < 4; c++) begin
        ping_t[c] += 32'(tk); jack_t[c] += 32'(tk); tap_t[c] += 32'(tk); flash_t[c] += 32'(tk);
      end
      for (int c = 0; c < 4; c++) channel_pass(c, taps[c], pings[c], jacks[c], sk[c]);
      if (tk != 0)
        for (int c = 0; c < 4; c++) envelope(c, tk, jacks[c]);
      e.leds = 0;
      for (int c = 0; c < 4; c++) begin
        e.lvl[c] = lvl_q[c]; e.leds[c] = led[c];
      end
      levels_due.push_back(e);
    endfunction

    task match_result(lfo_out_t got);
      lfo_out_t e;
      if (levels_due.size() == 0) begin
        report("result transfer with nothing outstanding");
      end else begin
        e = levels_due.pop_front();
        for (int c = 0; c < 4; c++)
          if (got.lvl[c] !== e.lvl[c])
            report($sformatf("level_ch%0d got %0d want %0d", c, got.lvl[c], e.lvl[c]));
        if (got.leds !== e.leds)
          report($sformatf("led_bits got %b want %b", got.leds, e.leds));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  always #6 clk = ~clk;

  qpsl_in_if  sample_if ();
  qpsl_out_if result_if ();
  qpsl_cfg_if cfg_if ();

  quad_ping_skew_lfo dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  lfo_tracker lfo = new();

  // idling knobs, percent per cycle
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;

  // per-channel stimulus shaping
  int unsigned ping_per [4], ping_cnt [4], tap_left [4], jack_left [4];
  bit          ping_on [4];
  bit [11:0]   cur_skew [4];

  // result side: ready toggled at the falling edge, transfers taken at the rising edge
  initial begin
    result_if.ready = 0;
    forever begin
      @(negedge clk);
      result_if.ready = ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    lfo_out_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got.lvl[0] = result_if.level_ch0; got.lvl[1] = result_if.level_ch1;
      got.lvl[2] = result_if.level_ch2; got.lvl[3] = result_if.level_ch3;
      got.leds = result_if.led_bits;
      lfo.match_result(got);
    end
  end

  // one sample transfer, with a random hold-off first when the sender idles
  task send_item(bit [7:0] tk, bit [3:0] taps, bit [3:0] pings, bit [3:0] jacks,
                 bit [11:0] s0, bit [11:0] s1, bit [11:0] s2, bit [11:0] s3);
    bit [11:0] sk [4];
    sk[0] = s0; sk[1] = s1; sk[2] = s2; sk[3] = s3;
    while ($urandom_range(99) < send_idle) begin
      sample_if.valid = 0;
      @(negedge clk);
    end
    sample_if.valid = 1;
    sample_if.elapsed_ticks = tk;
    sample_if.tap_levels = taps;
    sample_if.ping_levels = pings;
    sample_if.reset_levels = jacks;
    sample_if.skew_ch0 = s0; sample_if.skew_ch1 = s1;
    sample_if.skew_ch2 = s2; sample_if.skew_ch3 = s3;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    lfo.take_sample(tk, taps, pings, jacks, sk);
    @(negedge clk);
    sample_if.valid = 0;
  endtask

  task write_reg(qpsl_pkg::reg_idx_t idx, bit [15:0] val);
    cfg_if.valid = 1;
    cfg_if.index = idx;
    cfg_if.data = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    lfo.set_reg(idx, val);
    @(negedge clk);
    cfg_if.valid = 0;
  endtask

  // block is idle once nothing is owed and the recompute latency has passed
  task drain();
    while (lfo.levels_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly musical traffic: steady pings, short taps, rare long holds, reset pulses,
  // slowly wandering skew; the rest is raw noise
  task random_item();
    bit [7:0] tk;
    bit [3:0] taps, pings, jacks;
    int       j;
    if ($urandom_range(99) < 12) begin
      send_item($urandom_range(255), $urandom_range(15), $urandom_range(15),
                $urandom_range(15), $urandom_range(4095), $urandom_range(4095),
                $urandom_range(4095), $urandom_range(4095));
      return;
    end
    if ($urandom_range(99) < 5) tk = 0;
    else if ($urandom_range(99) < 5) tk = $urandom_range(255);
    else tk = $urandom_range(1, 12);
    for (int c = 0; c < 4; c++) begin
      if ($urandom_range(149) == 0) ping_per[c] = $urandom_range(2, 60);
      ping_cnt[c]++;
      pings[c] = ping_on[c] && ((ping_cnt[c] % ping_per[c]) < ping_per[c] / 2);
      if (tap_left[c] == 0 && $urandom_range(60) == 0)
        tap_left[c] = ($urandom_range(9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 4);
      taps[c] = (tap_left[c] != 0);
      if (tap_left[c] != 0) tap_left[c]--;
      if (jack_left[c] == 0 && $urandom_range(40) == 0) jack_left[c] = $urandom_range(1, 3);
      jacks[c] = (jack_left[c] != 0);
      if (jack_left[c] != 0) jack_left[c]--;
      if ($urandom_range(30) == 0) begin
        cur_skew[c] = $urandom_range(4095);
      end else begin
        j = int'(cur_skew[c]) + $urandom_range(6) - 3;
        cur_skew[c] = (j < 0) ? 12'd0 : (j > 4095) ? 12'd4095 : 12'(j);
      end
    end
    send_item(tk, taps, pings, jacks, cur_skew[0], cur_skew[1], cur_skew[2], cur_skew[3]);
  endtask

  initial begin
    bit [15:0] settings [5][4];
    int unsigned idle_send [5], idle_recv [5];

    sample_if.valid = 0; sample_if.elapsed_ticks = 0; sample_if.tap_levels = 0;
    sample_if.ping_levels = 0; sample_if.reset_levels = 0;
    sample_if.skew_ch0 = 0; sample_if.skew_ch1 = 0; sample_if.skew_ch2 = 0;
    sample_if.skew_ch3 = 0;
    cfg_if.valid = 0; cfg_if.index = qpsl_pkg::REG_DRIFT; cfg_if.data = 0;

    // register sets: reset values, all-zero, all-max, tight, random
    settings[0] = '{16'd50, 16'd15000, 16'd4000, 16'd50};
    settings[1] = '{16'd0, 16'd0, 16'd0, 16'd0};
    settings[2] = '{16'd4095, 16'd65535, 16'd4095, 16'd255};
    settings[3] = '{16'd20, 16'd300, 16'd30, 16'd10};
    settings[4] = '{16'($urandom_range(4095)), 16'($urandom_range(65535)),
                    16'($urandom_range(4095)), 16'($urandom_range(255))};
    idle_send = '{0, 50, 0, 21, 0};
    idle_recv = '{0, 0, 50, 21, 0};

    repeat (3) @(posedge clk);
    rst = 0;
    @(negedge clk);

    // directed: tick extremes, every curve band, tap/ping/reset edges, long hold
    send_item(0, 0, 0, 0, 0, 0, 0, 0);
    send_item(10, 4'hF, 0, 0, 0, 30, 55, 90);
    send_item(255, 0, 0, 0, 130, 2000, 4001, 4095);
    send_item(100, 4'hF, 0, 0, 131, 1975, 2125, 4000);
    send_item(5, 0, 0, 0, 131, 1975, 2125, 4000);
    send_item(150, 4'hF, 0, 0, 31, 56, 91, 12'hFFF);
    send_item(20, 0, 4'hF, 0, 31, 56, 91, 12'hFFF);
    send_item(20, 0, 0, 4'hF, 31, 56, 91, 12'hFFF);
    send_item(40, 0, 4'hF, 4'hF, 3000, 1000, 2050, 500);
    send_item(40, 0, 0, 0, 3000, 1000, 2050, 500);
    send_item(41, 0, 4'hF, 0, 3000, 1000, 2050, 500);
    send_item(0, 0, 0, 4'h5, 3000, 1000, 2050, 500);
    send_item(255, 0, 0, 4'hA, 0, 4095, 0, 4095);
    send_item(255, 0, 4'hF, 0, 4095, 0, 4095, 0);
    send_item(1, 0, 0, 0, 4095, 0, 4095, 0);
    for (int k = 0; k < 8; k++) send_item(255, 4'hF, 0, 0, 2500, 2500, 2500, 2500);
    send_item(3, 0, 0, 0, 2500, 2500, 2500, 2500);

    for (int c = 0; c < 4; c++) begin
      ping_per[c] = $urandom_range(2, 60); ping_cnt[c] = 0;
      tap_left[c] = 0; jack_left[c] = 0; cur_skew[c] = $urandom_range(4095);
    end

    for (int p = 0; p < 5; p++) begin
      drain();
      send_idle = 0; recv_stall = 0;
      for (int r = 0; r < 4; r++) write_reg(qpsl_pkg::reg_idx_t'(r), settings[p][r]);
      send_idle = idle_send[p]; recv_stall = idle_recv[p];
      for (int c = 0; c < 4; c++) ping_on[c] = ($urandom_range(3) != 0);
      for (int k = 0; k < 205; k++) begin
        // let the result side catch up completely once mid-run
        if (p == 1 && k == 100)
          while (lfo.levels_due.size() != 0) @(negedge clk);
        random_item();
      end
    end

    while (lfo.levels_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (lfo.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/qpsl_pkg.sv
hw/rtl/qpsl_in_if.sv
hw/rtl/qpsl_out_if.sv
hw/rtl/qpsl_cfg_if.sv
hw/rtl/qpsl_div.sv
hw/rtl/qpsl_lane.sv
hw/rtl/quad_ping_skew_lfo.sv
sim/quad_ping_skew_lfo_tb.sv
